[sv/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GWPM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define GWPM_ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define GWPM_ASSERT(lbl, clk, rstn, prop)
`define GWPM_ASSERT_NEXT(lbl, clk, rstn, cond, expr)
`endif
`endif

[sv/gwpm_pkg.sv]
// types and constants of the gaussian weighted pixel merge
package gwpm_pkg;

    localparam int RAD_W = 24;
    localparam int OFF_W = 12;
    localparam int PIX_W = 16;
    localparam int POS_W = 12;
    localparam int CFG_W = 13;
    localparam int SUM_W = 48;
    localparam int WT_W  = 32;
    localparam int FAC_W = 16;

    localparam logic [PIX_W-1:0] ONE_Q15 = 16'd32768;
    localparam logic [CFG_W-1:0] MAX_SIZE = 13'd4096;

    // reciprocals for floor division by six and by twenty-four
    localparam logic [23:0] RECIP_6  = 24'd11184811;
    localparam int          SHIFT_6  = 26;
    localparam logic [20:0] RECIP_24 = 21'd1398102;
    localparam int          SHIFT_24 = 25;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [RAD_W-1:0] radiance_r;
        logic [RAD_W-1:0] radiance_g;
        logic [RAD_W-1:0] radiance_b;
        logic [OFF_W-1:0] offset_x;
        logic [OFF_W-1:0] offset_y;
        logic             last_sample;
    } t_sample;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_r;
        logic [PIX_W-1:0] pixel_g;
        logic [PIX_W-1:0] pixel_b;
        logic [POS_W-1:0] pixel_col;
        logic [POS_W-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic mul;
        logic acc;
        logic div_start;
    } t_lane_ctrl;

endpackage

[sv/gwpm_samp_if.sv]
// sample and pixel channel interfaces
interface gwpm_samp_if;
    logic              valid;
    logic              ready;
    gwpm_pkg::t_sample data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gwpm_pix_if;
    logic             valid;
    logic             ready;
    gwpm_pkg::t_pixel data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/gwpm_gauss.sv]
// gaussian factor of one sub-pixel offset, series evaluated on one shared multiplier
module gwpm_gauss #(
    parameter int OFFSET_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gwpm_pkg::OFF_W-1:0]   i_offset,
    output logic                         o_done,
    output logic [gwpm_pkg::FAC_W-1:0]   o_factor
);

    typedef enum logic [2:0] {G_IDLE, G_SQ, G_T2, G_T3, G_T4, G_REC, G_SUM} t_gstate;

    localparam logic [OFFSET_BITS-1:0] HALF = OFFSET_BITS'(1) << (OFFSET_BITS - 1);
    localparam int SQ_SHIFT = 39 - 2 * OFFSET_BITS;

    t_gstate r_state;
    logic [OFFSET_BITS-1:0] r_d;
    logic [29:0] r_t;
    logic [26:0] r_t2;
    logic [23:0] r_t3;
    logic [20:0] r_t4;
    logic [21:0] r_q6;
    logic [16:0] r_q24;

    logic [15:0]            off16;
    logic [OFFSET_BITS-1:0] u;
    logic [OFFSET_BITS-1:0] n_d;
    logic [2*OFFSET_BITS-1:0] dd;
    logic [63:0]            t_wide;
    logic [29:0]            mul_a;
    logic [29:0]            mul_b;
    logic [59:0]            mul_p;
    logic [47:0]            p6;
    logic [41:0]            p24;
    logic [33:0]            e;

    assign off16 = 16'(i_offset);
    assign u     = off16[OFFSET_BITS-1:0];
    assign n_d   = (u >= HALF) ? (u - HALF) : (HALF - u);
    assign dd    = (2*OFFSET_BITS)'(r_d) * (2*OFFSET_BITS)'(r_d);
    assign t_wide = (64'(dd) << SQ_SHIFT) >> 8;

    always_comb begin
        mul_a = r_t;
        case (r_state)
            G_T2:    mul_b = r_t;
            G_T3:    mul_b = 30'(r_t2);
            G_T4:    mul_b = 30'(r_t3);
            default: mul_b = r_t;
        endcase
    end

    assign mul_p = 60'(mul_a) * 60'(mul_b);
    assign p6    = 48'(r_t3) * 48'(gwpm_pkg::RECIP_6);
    assign p24   = 42'(r_t4) * 42'(gwpm_pkg::RECIP_24);
    assign e     = (34'd1 << 32) - 34'(r_t) + 34'(r_t2 >> 1) - 34'(r_q6) + 34'(r_q24);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == G_SUM);
            case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_d     <= n_d;
                        r_state <= G_SQ;
                    end
                end
                G_SQ: begin
                    r_t     <= t_wide[29:0];
                    r_state <= G_T2;
                end
                G_T2: begin
                    r_t2    <= mul_p[58:32];
                    r_state <= G_T3;
                end
                G_T3: begin
                    r_t3    <= mul_p[55:32];
                    r_state <= G_T4;
                end
                G_T4: begin
                    r_t4    <= mul_p[52:32];
                    r_state <= G_REC;
                end
                G_REC: begin
                    r_q6    <= p6[gwpm_pkg::SHIFT_6 +: 22];
                    r_q24   <= p24[gwpm_pkg::SHIFT_24 +: 17];
                    r_state <= G_SUM;
                end
                G_SUM: begin
                    o_factor <= 16'((e + 34'd65536) >> 17);
                    r_state  <= G_IDLE;
                end
                default: r_state <= G_IDLE;
            endcase
        end
    end

endmodule

[sv/gwpm_lane.sv]
// one color lane: weighted accumulation and restoring division
module gwpm_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gwpm_pkg::t_lane_ctrl        i_ctrl,
    input  logic [gwpm_pkg::RAD_W-1:0]  i_rad,
    input  logic [15:0]                 i_weight,
    input  logic [gwpm_pkg::WT_W-1:0]   i_wt_total,
    output logic                        o_busy,
    output logic [gwpm_pkg::PIX_W-1:0]  o_pixel
);

    logic [39:0] r_prod;
    logic [47:0] r_sum;
    logic [32:0] r_den;
    logic [32:0] r_rem;
    logic [15:0] r_low;
    logic [15:0] r_quo;
    logic [3:0]  r_cnt;

    logic [48:0] sum_ext;
    logic [48:0] num;
    logic [32:0] den;
    logic [33:0] trial;
    logic        q_bit;
    logic [15:0] n_quo;

    assign sum_ext = 49'(r_sum) + 49'(r_prod);
    assign num     = 49'(r_sum) + 49'(i_wt_total);
    assign den     = {i_wt_total, 1'b0};
    assign trial   = {r_rem, r_low[15]};
    assign q_bit   = (trial >= 34'(r_den));
    assign n_quo   = {r_quo[14:0], q_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            o_busy <= 1'b0;
        end else begin
            if (i_ctrl.mul) begin
                r_prod <= 40'(i_rad) * 40'(i_weight);
            end
            if (i_ctrl.acc) begin
                r_sum <= sum_ext[48] ? '1 : sum_ext[47:0];
            end
            if (i_ctrl.div_start) begin
                r_sum <= '0;
                r_den <= den;
                r_low <= num[15:0];
                r_rem <= num[48:16];
                r_quo <= '0;
                r_cnt <= 4'd15;
                if (num >= {den, 16'd0}) begin
                    o_pixel <= gwpm_pkg::ONE_Q15;
                end else begin
                    o_busy <= 1'b1;
                end
            end else if (o_busy) begin
                r_rem <= q_bit ? 33'(trial - 34'(r_den)) : trial[32:0];
                r_low <= {r_low[14:0], 1'b0};
                r_quo <= n_quo;
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    o_busy  <= 1'b0;
                    o_pixel <= (n_quo > gwpm_pkg::ONE_Q15) ? gwpm_pkg::ONE_Q15 : n_quo;
                end
            end
        end
    end

endmodule

[sv/gaussian_weighted_pixel_merge_top.sv]
// top level of the gaussian weighted pixel merge
// samples arrive grouped by pixel in raster order; each one is weighted by the
// product of two per-axis gaussian factors, computed by two factor units in
// parallel on a shared series multiplier each. three color lanes multiply and
// accumulate radiance side by side; the top keeps the weight total and the
// raster position. on the last sample of a pixel every lane divides its sum by
// twice the weight total with a 16-step restoring divider, and the merge stage
// packs the three channels with column and row into the output register.
// a sample passes acceptance, the factor unit, the weight multiply and the lane
// multiply and add before the next one is taken; a last sample adds the division
// and the output load. the output register lets a finished pixel wait while the
// next samples are taken in.
`include "assert_macros.svh"
module gaussian_weighted_pixel_merge_top #(
    parameter int OFFSET_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gwpm_samp_if.sink                     i_samp,
    gwpm_pix_if.source                    o_pix,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [gwpm_pkg::CFG_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_GAUSS, S_MUL, S_ADD, S_DIVS, S_DIV, S_OUT} t_state;

    t_state r_state;
    logic [gwpm_pkg::CFG_W-1:0] r_width;
    logic [gwpm_pkg::CFG_W-1:0] r_height;
    logic [gwpm_pkg::POS_W-1:0] r_col;
    logic [gwpm_pkg::POS_W-1:0] r_row;
    logic [gwpm_pkg::WT_W-1:0]  r_wt;
    logic [15:0]                r_w;
    gwpm_pkg::t_sample          r_samp;
    logic                       r_out_valid;
    gwpm_pkg::t_pixel           r_out;

    logic                       accept;
    logic                       gx_done;
    logic                       gy_done;
    logic [gwpm_pkg::FAC_W-1:0] fx;
    logic [gwpm_pkg::FAC_W-1:0] fy;
    logic [31:0]                fprod;
    logic [32:0]                wt_sum;
    gwpm_pkg::t_lane_ctrl       lane_ctrl;
    logic [2:0]                 lane_busy;
    logic [gwpm_pkg::PIX_W-1:0] pix_r;
    logic [gwpm_pkg::PIX_W-1:0] pix_g;
    logic [gwpm_pkg::PIX_W-1:0] pix_b;
    logic [gwpm_pkg::CFG_W-1:0] eff_w;
    logic [gwpm_pkg::CFG_W-1:0] eff_h;
    logic                       out_free;

    assign i_samp.ready = (r_state == S_IDLE);
    assign accept       = i_samp.valid && i_samp.ready;
    assign o_pix.valid  = r_out_valid;
    assign o_pix.data   = r_out;
    assign out_free     = !r_out_valid || o_pix.ready;

    // per-axis gaussian factors
    gwpm_gauss #(.OFFSET_BITS(OFFSET_BITS)) u_gauss_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_offset(i_samp.data.offset_x), .o_done(gx_done), .o_factor(fx)
    );
    gwpm_gauss #(.OFFSET_BITS(OFFSET_BITS)) u_gauss_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept),
        .i_offset(i_samp.data.offset_y), .o_done(gy_done), .o_factor(fy)
    );

    assign fprod  = 32'(fx) * 32'(fy);
    assign wt_sum = 33'(r_wt) + 33'(r_w);

    always_comb begin
        lane_ctrl.mul       = (r_state == S_MUL);
        lane_ctrl.acc       = (r_state == S_ADD);
        lane_ctrl.div_start = (r_state == S_DIVS);
    end

    // color lanes
    gwpm_lane u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(lane_ctrl), .i_rad(r_samp.radiance_r),
        .i_weight(r_w), .i_wt_total(r_wt), .o_busy(lane_busy[0]), .o_pixel(pix_r)
    );
    gwpm_lane u_lane_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(lane_ctrl), .i_rad(r_samp.radiance_g),
        .i_weight(r_w), .i_wt_total(r_wt), .o_busy(lane_busy[1]), .o_pixel(pix_g)
    );
    gwpm_lane u_lane_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(lane_ctrl), .i_rad(r_samp.radiance_b),
        .i_weight(r_w), .i_wt_total(r_wt), .o_busy(lane_busy[2]), .o_pixel(pix_b)
    );

    // film size clamped to one through 4096
    always_comb begin
        eff_w = (r_width == '0) ? 13'd1 :
                (r_width > gwpm_pkg::MAX_SIZE) ? gwpm_pkg::MAX_SIZE : r_width;
        eff_h = (r_height == '0) ? 13'd1 :
                (r_height > gwpm_pkg::MAX_SIZE) ? gwpm_pkg::MAX_SIZE : r_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= 13'd640;
            r_height    <= 13'd480;
            r_col       <= '0;
            r_row       <= '0;
            r_wt        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gwpm_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    gwpm_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            // output item taken and no new pixel loaded behind it
            if (o_pix.ready && !((r_state == S_OUT) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_samp  <= i_samp.data;
                        r_state <= S_GAUSS;
                    end
                end
                S_GAUSS: begin
                    // rounded product of the two factors, q1.15
                    if (gx_done) begin
                        r_w     <= 16'((33'(fprod) + 33'd16384) >> 15);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ADD;
                S_ADD: begin
                    r_wt    <= wt_sum[32] ? '1 : wt_sum[31:0];
                    r_state <= r_samp.last_sample ? S_DIVS : S_IDLE;
                end
                S_DIVS: r_state <= S_DIV;
                S_DIV: begin
                    if (lane_busy == 3'b000) begin
                        r_wt    <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // merge stage: pack channels and raster position
                    if (out_free) begin
                        r_out.pixel_r   <= pix_r;
                        r_out.pixel_g   <= pix_g;
                        r_out.pixel_b   <= pix_b;
                        r_out.pixel_col <= r_col;
                        r_out.pixel_row <= r_row;
                        r_out_valid     <= 1'b1;
                        if ((13'(r_col) + 13'd1) >= eff_w) begin
                            r_col <= '0;
                            r_row <= ((13'(r_row) + 13'd1) >= eff_h) ? '0 : r_row + 12'd1;
                        end else begin
                            r_col <= r_col + 12'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // both factor units run in lockstep
    `GWPM_ASSERT(a_gauss_lockstep, i_clk, i_rst_n, gx_done == gy_done)
    // a factor result only shows up while the sequencer waits for it
    `GWPM_ASSERT(a_gauss_when_waiting, i_clk, i_rst_n, gx_done |-> r_state == S_GAUSS)
    // the lanes divide only with a nonzero weight total
    `GWPM_ASSERT(a_div_weight, i_clk, i_rst_n, (r_state == S_DIVS) |-> (r_wt != '0))
    // emitted red and green channels stay within one
    `GWPM_ASSERT_NEXT(a_out_clamped, i_clk, i_rst_n, (r_state == S_OUT) && out_free,
        r_out.pixel_r <= gwpm_pkg::ONE_Q15 && r_out.pixel_g <= gwpm_pkg::ONE_Q15)

endmodule

[dv/tb_gaussian_weighted_pixel_merge_top.sv]
// self-checking testbench of the gaussian weighted pixel merge top level
module tb_gaussian_weighted_pixel_merge_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFF_BITS    = 12;
    localparam int STALL_LIMIT = 5000;   // cycles with no item moving on either side
    localparam int DRAIN_WAIT  = 40;     // covers the accept, factor and division path

    localparam longint unsigned CAP48 = (64'd1 << 48) - 1;
    localparam longint unsigned CAP32 = 64'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [gwpm_pkg::CFG_W-1:0] i_cfg_data;

    gwpm_samp_if samp_ch ();
    gwpm_pix_if  pix_ch ();

    gaussian_weighted_pixel_merge_top #(.OFFSET_BITS(OFF_BITS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_samp     (samp_ch),
        .o_pix      (pix_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block: registers, sums and raster position
    longint unsigned film_width, film_height;
    longint unsigned acc_red, acc_green, acc_blue, acc_weight;
    longint unsigned cur_col, cur_row;

    gwpm_pkg::t_pixel expected_pixels[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int pixels_checked;
    int error_count;
    int stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // per-axis gaussian factor exp(-(s-0.5)^2/2), q1.15
    function automatic longint unsigned axis_factor(logic [gwpm_pkg::OFF_W-1:0] off);
        longint unsigned half, u, d, t, t2, t3, t4, e;
        half = 64'd1 << (OFF_BITS - 1);
        u    = 64'(off) & ((64'd1 << OFF_BITS) - 1);
        d    = (u >= half) ? (u - half) : (half - u);
        t    = ((d * d) << (39 - 2 * OFF_BITS)) >> 8;
        t2   = (t * t) >> 32;
        t3   = (t2 * t) >> 32;
        t4   = (t3 * t) >> 32;
        e    = (64'd1 << 32) - t + t2 / 2 - t3 / 6 + t4 / 24;
        return (e + (64'd1 << 16)) >> 17;
    endfunction

    function automatic longint unsigned add_capped(longint unsigned a, longint unsigned b,
                                                   longint unsigned cap);
        longint unsigned s;
        s = a + b;
        return (s > cap) ? cap : s;
    endfunction

    function automatic longint unsigned clamp_size(longint unsigned v);
        if (v < 1) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function automatic logic [gwpm_pkg::PIX_W-1:0] normalize(longint unsigned sum,
                                                             longint unsigned wt);
        longint unsigned q;
        if (wt == 0) return '0;
        q = (sum + wt) / (2 * wt);
        return (q > 32768) ? gwpm_pkg::ONE_Q15 : q[gwpm_pkg::PIX_W-1:0];
    endfunction

    // accumulate one accepted sample, queue the pixel on a last sample
    task automatic merge_sample(gwpm_pkg::t_sample s);
        longint unsigned w;
        gwpm_pkg::t_pixel px;
        w = (axis_factor(s.offset_x) * axis_factor(s.offset_y) + (64'd1 << 14)) >> 15;
        acc_red    = add_capped(acc_red,   64'(s.radiance_r) * w, CAP48);
        acc_green  = add_capped(acc_green, 64'(s.radiance_g) * w, CAP48);
        acc_blue   = add_capped(acc_blue,  64'(s.radiance_b) * w, CAP48);
        acc_weight = add_capped(acc_weight, w, CAP32);
        if (s.last_sample) begin
            px.pixel_r   = normalize(acc_red, acc_weight);
            px.pixel_g   = normalize(acc_green, acc_weight);
            px.pixel_b   = normalize(acc_blue, acc_weight);
            px.pixel_col = cur_col[gwpm_pkg::POS_W-1:0];
            px.pixel_row = cur_row[gwpm_pkg::POS_W-1:0];
            expected_pixels.push_back(px);
            acc_red = 0; acc_green = 0; acc_blue = 0; acc_weight = 0;
            // position past a shrunk register wraps on the next advance
            if (cur_col + 1 >= clamp_size(film_width)) begin
                cur_col = 0;
                cur_row = (cur_row + 1 >= clamp_size(film_height)) ? 0 : cur_row + 1;
            end else begin
                cur_col = cur_col + 1;
            end
        end
    endtask

    // drive one sample, with a random gap before it, until the block takes it
    task automatic send_sample(gwpm_pkg::t_sample s);
        while ($urandom_range(99) < tx_idle_pct) begin
            samp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        samp_ch.valid <= 1'b1;
        samp_ch.data  <= s;
        do @(posedge i_clk); while (!samp_ch.ready);
        merge_sample(s);
        items_sent++;
    endtask

    task automatic end_burst();
        samp_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // block is idle once every pixel is out and the pipeline has drained
    task automatic wait_idle();
        end_burst();
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [gwpm_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == gwpm_pkg::CFG_WIDTH) film_width = 64'(val);
        else film_height = 64'(val);
    endtask

    task automatic set_film(logic [gwpm_pkg::CFG_W-1:0] w, logic [gwpm_pkg::CFG_W-1:0] h);
        wait_idle();
        write_reg(gwpm_pkg::CFG_WIDTH, w);
        write_reg(gwpm_pkg::CFG_HEIGHT, h);
    endtask

    function automatic gwpm_pkg::t_sample make_sample(
        logic [gwpm_pkg::RAD_W-1:0] r, logic [gwpm_pkg::RAD_W-1:0] g,
        logic [gwpm_pkg::RAD_W-1:0] b, logic [gwpm_pkg::OFF_W-1:0] ox,
        logic [gwpm_pkg::OFF_W-1:0] oy, logic last);
        gwpm_pkg::t_sample s;
        s.radiance_r = r; s.radiance_g = g; s.radiance_b = b;
        s.offset_x = ox; s.offset_y = oy; s.last_sample = last;
        return s;
    endfunction

    function automatic logic [gwpm_pkg::OFF_W-1:0] rand_offset();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 12'd2048;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [gwpm_pkg::RAD_W-1:0] rand_radiance();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 24'($urandom_range(65536));   // around 1.0
            default: return 24'($urandom_range(24'hFF_FFFF));
        endcase
    endfunction

    // extremes of every field, single-sample pixels and one of three samples, tiny and reset film size
    task automatic test_directed();
        send_sample(make_sample('0, '0, '0, '0, '0, 1'b1));
        send_sample(make_sample('1, '1, '1, '1, '1, 1'b1));
        send_sample(make_sample('1, '0, 24'h01_0000, 12'd2048, 12'd2048, 1'b1));
        send_sample(make_sample(24'h00_8000, 24'h01_0000, 24'h02_0000, 12'd2047, 12'd1, 1'b0));
        send_sample(make_sample(24'h01_0000, '0, 24'h00_4000, 12'd4095, 12'd0, 1'b0));
        send_sample(make_sample('1, 24'h00_0001, '0, 12'd1, 12'd4094, 1'b1));
        send_sample(make_sample(24'h55_5555, 24'hAA_AAAA, 24'h0F_0F0F, 12'hAAA, 12'h555, 1'b1));
        send_sample(make_sample(24'hAA_AAAA, 24'h55_5555, 24'hF0_F0F0, 12'h555, 12'hAAA, 1'b1));
        // single pixel frame, then zero registers used as one
        set_film(13'd1, 13'd1);
        repeat (3) send_sample(make_sample(rand_radiance(), rand_radiance(), rand_radiance(),
                                           rand_offset(), rand_offset(), 1'b1));
        set_film(13'd0, 13'd0);
        repeat (3) send_sample(make_sample(rand_radiance(), rand_radiance(), rand_radiance(),
                                           rand_offset(), rand_offset(), 1'b1));
        // two by two frame wrapping in both axes
        set_film(13'd2, 13'd2);
        repeat (5) send_sample(make_sample(rand_radiance(), rand_radiance(), rand_radiance(),
                                           rand_offset(), rand_offset(), 1'b1));
    endtask

    // full-scale samples at the center weight drive the red and green sums into saturation
    task automatic test_saturation();
        for (int k = 0; k < 520; k++)
            send_sample(make_sample('1, '1, 24'h00_1000, 12'd2048, 12'd2048, k == 519));
    endtask

    // whole pixels of random samples; a few long pixels among short ones
    task automatic test_random_pixels(int n_items);
        int n_samp;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            n_samp = ($urandom_range(19) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
            for (int k = 0; k < n_samp; k++)
                send_sample(make_sample(rand_radiance(), rand_radiance(), rand_radiance(),
                                        rand_offset(), rand_offset(), k == n_samp - 1));
            sent += n_samp;
        end
    endtask

    // receiver: random back-pressure, and the check of each pixel against the oldest one queued
    always @(posedge i_clk) begin
        gwpm_pkg::t_pixel got, want;
        if (pix_ch.valid && pix_ch.ready) begin
            got = pix_ch.data;
            if (expected_pixels.size() == 0) begin
                $error("pixel out with none expected: col %0d row %0d",
                       got.pixel_col, got.pixel_row);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (got.pixel_r !== want.pixel_r) begin
                    $error("pixel_r expected %0d actual %0d", want.pixel_r, got.pixel_r);
                    error_count++;
                end
                if (got.pixel_g !== want.pixel_g) begin
                    $error("pixel_g expected %0d actual %0d", want.pixel_g, got.pixel_g);
                    error_count++;
                end
                if (got.pixel_b !== want.pixel_b) begin
                    $error("pixel_b expected %0d actual %0d", want.pixel_b, got.pixel_b);
                    error_count++;
                end
                if (got.pixel_col !== want.pixel_col) begin
                    $error("pixel_col expected %0d actual %0d", want.pixel_col, got.pixel_col);
                    error_count++;
                end
                if (got.pixel_row !== want.pixel_row) begin
                    $error("pixel_row expected %0d actual %0d", want.pixel_row, got.pixel_row);
                    error_count++;
                end
            end
            pixels_checked++;
        end
        pix_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge i_clk) begin
        if ((samp_ch.valid && samp_ch.ready) || (pix_ch.valid && pix_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d pixels outstanding", expected_pixels.size());
            $display("tb_gaussian_weighted_pixel_merge_top failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= gwpm_pkg::CFG_WIDTH;
        i_cfg_data    <= '0;
        samp_ch.valid <= 1'b0;
        samp_ch.data  <= '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        items_sent = 0;
        film_width = 640; film_height = 480;
        acc_red = 0; acc_green = 0; acc_blue = 0; acc_weight = 0;
        cur_col = 0; cur_row = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender rarely idles, receiver mostly stalls; reset film size first
        tx_idle_pct = 6; rx_idle_pct = 66;
        test_directed();
        test_saturation();
        set_film(13'd4096, 13'd3);
        test_random_pixels(290);
        // shrink the width below the current column mid-frame
        tx_idle_pct = 66; rx_idle_pct = 6;
        set_film(13'd5, 13'd8191);
        test_random_pixels(290);
        // no idling at all
        tx_idle_pct = 0; rx_idle_pct = 0;
        set_film(13'd3, 13'd4);
        test_random_pixels(140);
        set_film(13'd8191, 13'd2);
        test_random_pixels(140);

        end_burst();
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d samples and checked %0d pixels", items_sent, pixels_checked);
        $display("film sizes 0 to 8191, saturated sums, three back-pressure mixes");
        if (error_count == 0)
            $display("tb_gaussian_weighted_pixel_merge_top passed");
        else
            $display("tb_gaussian_weighted_pixel_merge_top failed");
        $finish;
    end
endmodule
